### sv/cpc_pkg.sv
`timescale 1ns / 1ps
package cpc_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;

  // Item kinds.
  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;
  localparam logic [1:0] KIND_NOP      = 2'd3;

  // Register indexes.
  localparam logic CFG_BASE_VALUE = 1'b0;
  localparam logic CFG_THRESHOLD  = 1'b1;

  localparam logic [6:0]  BASE_VALUE_RESET = 7'd60;
  localparam logic [6:0]  BASE_VALUE_LIMIT = 7'd5;
  localparam logic [5:0]  SCALE_BRIGHT     = 6'd3;
  localparam logic [5:0]  SCALE_DIM        = 6'd35;
  localparam logic [19:0] COORD_MAX        = 20'hFFFFF;
  localparam logic [19:0] THRESH_DEFAULT   = 20'd10240;
  localparam logic [8:0]  HUE_WRAP         = 9'd360;

  localparam int ROOT_W = 21;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int LIM_W  = 2 * (ROOT_W + 1);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
    logic [7:0] proto_color;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  matched_color;
    logic [19:0] match_distance;
    logic [5:0]  entries_used;
  } result_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [19:0]        z;
    logic [7:0]         color;
  } cmd_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [19:0]        z;
    logic [7:0]         id;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN1,
    BK_ROOT,
    BK_LIMIT,
    BK_SCAN2,
    BK_RESULT
  } bk_state_t;

  typedef logic [14:0] sin_tab_t [0:90];

  // Quarter-wave sine in Q1.14, evaluated once at elaboration.
  function automatic logic [14:0] sine_q14(input int unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x = (longint'(a) * PI_Q30 + 64'd90) / 64'd180;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        default: term = term / 64'd110;
      endcase
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return 15'((sum + 64'd32768) >> 16);
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int a = 0; a <= 90; a++) begin
      t[a] = sine_q14(a);
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

### sv/cpc_front.sv
`timescale 1ns / 1ps
module cpc_front import cpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic [6:0] base_value,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic a_valid;
  logic [1:0] a_kind;
  logic [7:0] a_color;
  logic [6:0] a_sat;
  logic [14:0] a_sin;
  logic [14:0] a_cos;
  logic a_sin_neg;
  logic a_cos_neg;
  logic [19:0] a_z;
  logic b_valid;
  cmd_t b_cmd;

  logic b_en;
  logic a_en;
  logic [8:0] hm;
  logic [8:0] sidx;
  logic [8:0] cidx;
  logic sneg;
  logic cneg;
  logic [5:0] scale;
  logic [12:0] vs;
  logic [20:0] zz;
  logic [21:0] px;
  logic [21:0] py;
  logic [15:0] mx;
  logic [15:0] my;

  assign b_en = !b_valid || cmd_ready;
  assign a_en = !a_valid || b_en;
  assign in_ready = a_en;
  assign cmd_valid = b_valid;
  assign cmd = b_cmd;

  // Fold the hue into one quadrant of the sine table.
  always_comb begin
    hm = (in_item.hue >= HUE_WRAP) ? in_item.hue - HUE_WRAP : in_item.hue;
    if (hm <= 9'd90) begin
      sidx = hm;          cidx = 9'd90 - hm;  sneg = 1'b0; cneg = 1'b0;
    end else if (hm <= 9'd180) begin
      sidx = 9'd180 - hm; cidx = hm - 9'd90;  sneg = 1'b0; cneg = 1'b1;
    end else if (hm <= 9'd270) begin
      sidx = hm - 9'd180; cidx = 9'd270 - hm; sneg = 1'b1; cneg = 1'b1;
    end else begin
      sidx = 9'd360 - hm; cidx = hm - 9'd270; sneg = 1'b1; cneg = 1'b0;
    end
    scale = (base_value > BASE_VALUE_LIMIT) ? SCALE_BRIGHT : SCALE_DIM;
    vs = 13'(in_item.brightness) * 13'(scale);
    zz = {vs, 8'd0};
  end

  // Saturation times trig value, rounded half away from zero on the magnitude.
  always_comb begin
    px = 22'(a_sat) * 22'(a_cos) + 22'd32;
    py = 22'(a_sat) * 22'(a_sin) + 22'd32;
    mx = px[21:6];
    my = py[21:6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= in_valid;
      if (b_en) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && in_valid) begin
      a_kind <= in_item.kind;
      a_color <= in_item.proto_color;
      a_sat <= in_item.saturation;
      a_sin <= SIN_TAB[sidx[6:0]];
      a_cos <= SIN_TAB[cidx[6:0]];
      a_sin_neg <= sneg;
      a_cos_neg <= cneg;
      a_z <= (zz > 21'(COORD_MAX)) ? COORD_MAX : zz[19:0];
    end
    if (b_en && a_valid) begin
      b_cmd.kind <= a_kind;
      b_cmd.color <= a_color;
      b_cmd.z <= a_z;
      b_cmd.x <= a_cos_neg ? -$signed(20'(mx)) : $signed(20'(mx));
      b_cmd.y <= a_sin_neg ? -$signed(20'(my)) : $signed(20'(my));
    end
  end

endmodule

### sv/cpc_queue.sv
`timescale 1ns / 1ps
module cpc_queue import cpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t slots [2];
  logic wp;
  logic rp;
  logic [1:0] fill;
  logic push;
  logic pull;

  assign in_ready = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_cmd = slots[rp];
  assign push = in_valid && in_ready;
  assign pull = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pull) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pull);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_cmd;
  end

endmodule

### sv/cpc_isqrt.sv
`timescale 1ns / 1ps
module cpc_isqrt import cpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic busy;
  logic [CNT_W-1:0] steps;
  logic [SQ_W-1:0] val;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // One result bit per cycle, two radicand bits brought down each time.
  assign rem_sh = {rem[REM_W-3:0], val[SQ_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= CNT_W'(ROOT_W);
      val <= value;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      steps <= steps - CNT_W'(1);
      val <= val << 2;
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

### sv/cpc_back.sv
`timescale 1ns / 1ps
module cpc_back import cpc_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [19:0] distance_threshold,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_entry;
  bk_state_t state;
  bk_state_t state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] iss;
  cmd_t cur;
  logic p1_valid;
  logic p2_valid;
  logic [7:0] p2_id;
  logic [SQ_W-1:0] p2_sqx;
  logic [SQ_W-1:0] p2_sqy;
  logic [SQ_W-1:0] p2_sqz;
  logic [SQ_W-1:0] best_sq;
  logic [ROOT_W-1:0] root;
  logic [LIM_W-1:0] lim;
  logic sat_root;
  logic hit_found;
  logic [7:0] hit_id;
  logic pend_status;
  logic [7:0] pend_color;
  logic [19:0] pend_dist;

  logic pop;
  logic mem_we;
  logic issue;
  logic sqrt_start;
  logic out_load;
  logic scan_done;
  logic out_free;
  logic sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic signed [20:0] dx;
  logic signed [20:0] dy;
  logic signed [20:0] dz;
  logic signed [SQ_W-1:0] dxe;
  logic signed [SQ_W-1:0] dye;
  logic signed [SQ_W-1:0] dze;
  logic [SQ_W-1:0] sq_sum;
  logic [ROOT_W:0] root_inc;
  logic [19:0] dist_final;
  logic [19:0] thr_eff;

  cpc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (best_sq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign scan_done = (iss == count) && !p1_valid && !p2_valid;
  assign out_free = !out_valid || out_ready;
  assign sq_sum = p2_sqx + p2_sqy + p2_sqz;
  assign root_inc = (ROOT_W + 1)'(root) + (ROOT_W + 1)'(1);
  assign dist_final = sat_root ? COORD_MAX : root[19:0];
  assign thr_eff = (distance_threshold == '0) ? THRESH_DEFAULT : distance_threshold;

  always_comb begin
    dx = 21'(cur.x) - 21'(rd_entry.x);
    dy = 21'(cur.y) - 21'(rd_entry.y);
    dz = $signed({1'b0, cur.z}) - $signed({1'b0, rd_entry.z});
    dxe = SQ_W'(dx);
    dye = SQ_W'(dy);
    dze = SQ_W'(dz);
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == KIND_CLASSIFY && count != '0) state_next = BK_SCAN1;
          else state_next = BK_RESULT;
        end
      end
      BK_SCAN1: if (scan_done) state_next = BK_ROOT;
      BK_ROOT:  if (sqrt_done) state_next = BK_LIMIT;
      BK_LIMIT: state_next = BK_SCAN2;
      BK_SCAN2: if (scan_done) state_next = BK_RESULT;
      BK_RESULT: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == BK_IDLE);
    pop = (state == BK_IDLE) && cmd_valid;
    mem_we = pop && cmd.kind == KIND_ADD && count < FULL;
    issue = (state == BK_SCAN1 || state == BK_SCAN2) && iss < count;
    sqrt_start = (state == BK_SCAN1) && scan_done;
    out_load = (state == BK_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
      iss <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (pop || state == BK_LIMIT) iss <= '0;
      else if (issue) iss <= iss + CW'(1);
      if (pop && cmd.kind == KIND_CLEAR) count <= '0;
      else if (mem_we) count <= count + CW'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[AW-1:0]] <= '{x: cmd.x, y: cmd.y, z: cmd.z, id: cmd.color};
    rd_entry <= mem[iss[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    p2_sqx <= dxe * dxe;
    p2_sqy <= dye * dye;
    p2_sqz <= dze * dze;
    p2_id <= rd_entry.id;

    if (pop) begin
      cur <= cmd;
      best_sq <= '1;
      pend_status <= 1'b0;
      pend_color <= 8'd0;
      pend_dist <= 20'd0;
      case (cmd.kind)
        KIND_ADD:      pend_status <= (count >= FULL);
        KIND_CLASSIFY: if (count == '0) pend_dist <= COORD_MAX;
        default:       pend_status <= 1'b0;
      endcase
    end

    // First pass keeps the smallest squared distance.
    if (state == BK_SCAN1 && p2_valid && sq_sum < best_sq) best_sq <= sq_sum;

    if (state == BK_ROOT && sqrt_done) root <= sqrt_root;

    // Any entry whose rounded-down root equals the minimum is squared below (root + 1)^2.
    if (state == BK_LIMIT) begin
      lim <= root_inc * root_inc;
      sat_root <= (root >= ROOT_W'(COORD_MAX));
      hit_found <= 1'b0;
    end

    if (state == BK_SCAN2 && p2_valid && !hit_found &&
        (sat_root || LIM_W'(sq_sum) < lim)) begin
      hit_found <= 1'b1;
      hit_id <= p2_id;
    end

    if (state == BK_SCAN2 && scan_done) begin
      pend_dist <= dist_final;
      pend_color <= (dist_final > thr_eff) ? 8'd0 : hit_id;
    end

    if (out_load) begin
      out_result.status <= pend_status;
      out_result.matched_color <= pend_color;
      out_result.match_distance <= pend_dist;
      out_result.entries_used <= 6'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("entry count beyond table depth");
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == $past(count) + CW'(1))
    else $error("stored prototype not counted");
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN1 || state == BK_SCAN2) |-> iss <= count)
    else $error("scan index ran past the held entries");
`endif

endmodule

### sv/color_prototype_classifier.sv
`timescale 1ns / 1ps
// Nearest colour prototype classifier on an HSV cylinder.
// Input channel in_valid / in_ready / in_item carries one item per transfer: clear the
// table, add a prototype, classify a sample, or do nothing. Output channel out_valid /
// out_ready / out_result returns exactly one result per item, in item order.
// Registers are written over cfg_write_en / cfg_index / cfg_data: index 0 base_value,
// index 1 distance_threshold; write them only while no item is in flight.
// A front end converts each item to cylinder coordinates in two pipeline stages and
// hands it through a two-entry queue to the back end, which owns the prototype memory.
// Clear, add and no-op items pass the two front stages, the queue and the back end's
// idle and result states before out_valid rises; the back end takes a new item only
// once it is idle again. A classify in the back end takes one walk over the memory
// for the smallest squared distance, a one-bit-per-cycle square root, and a second
// walk for the earliest entry with that rounded distance; these steps set the rate.
// The front keeps accepting items while the back end is busy, until the queue fills.
// When the receiver stalls, the finished result waits in the output register and the
// back end holds the next one; the input stalls once both the queue and front fill.
// Reset (synchronous, rst high) empties the table, the queue and the output register and
// restores base_value to 60 and distance_threshold to 10240.
module color_prototype_classifier import cpc_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  logic [6:0] base_value;
  logic [19:0] distance_threshold;

  // Front to queue, and queue to back end.
  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Configuration registers; a write takes effect at the edge where it is presented.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_value <= BASE_VALUE_RESET;
      distance_threshold <= THRESH_DEFAULT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BASE_VALUE: base_value <= cfg_data[6:0];
        CFG_THRESHOLD:  distance_threshold <= cfg_data;
        default:        base_value <= base_value;
      endcase
    end
  end

  cpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .base_value (base_value),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  cpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  cpc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (q_valid),
    .cmd_ready          (q_ready),
    .cmd                (q_cmd),
    .distance_threshold (distance_threshold),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result         (out_result)
  );

endmodule

### dv/cpc_checker.sv
`timescale 1ns / 1ps
module cpc_checker import cpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_result,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  logic [6:0]  base_val;
  logic [19:0] thresh;
  int          px [DEPTH];
  int          py [DEPTH];
  longint      pz [DEPTH];
  logic [7:0]  pid [DEPTH];
  int          count;
  result_t     expected_q [$];

  assign pending = expected_q.size();

  // Quarter-wave sine in Q1.14, computed with the same series as the hardware table.
  function automatic int quarter_sine(int unsigned a);
    longint unsigned x, x2, term, sum;
    x = (longint'(a) * 64'd3373259426 + 64'd90) / 64'd180;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return int'((sum + 64'd32768) >> 16);
  endfunction

  function automatic int scale_coord(int sat, int t);
    int mag, m;
    mag = (t < 0) ? -t : t;
    m = (sat * mag + 32) >>> 6;
    return (t < 0) ? -m : m;
  endfunction

  task automatic hsv_to_point(input int h, input int sat, input int v,
                              output int x, output int y, output longint z);
    int c, s, sc;
    longint zz;
    h = h % 360;
    if (h <= 90) begin
      s = quarter_sine(h); c = quarter_sine(90 - h);
    end else if (h <= 180) begin
      s = quarter_sine(180 - h); c = -quarter_sine(h - 90);
    end else if (h <= 270) begin
      s = -quarter_sine(h - 180); c = -quarter_sine(270 - h);
    end else begin
      s = -quarter_sine(360 - h); c = quarter_sine(h - 270);
    end
    sc = (base_val > BASE_VALUE_LIMIT) ? 3 : 35;
    zz = longint'(v) * sc * 256;
    x = scale_coord(sat, c);
    y = scale_coord(sat, s);
    z = (zz > 1048575) ? 1048575 : zz;
  endtask

  function automatic longint floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Apply one accepted item to the shadow table and queue its expected result.
  task automatic predict_item(input in_item_t it);
    result_t r;
    int x, y;
    longint z, dx, dy, dz, d, best;
    logic [7:0] best_id;
    logic [19:0] thr;
    r = '0;
    case (it.kind)
      KIND_CLEAR: count = 0;
      KIND_ADD: begin
        if (count >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          hsv_to_point(it.hue, it.saturation, it.brightness, x, y, z);
          px[count] = x; py[count] = y; pz[count] = z; pid[count] = it.proto_color;
          count++;
        end
      end
      KIND_CLASSIFY: begin
        if (count == 0) begin
          r.match_distance = COORD_MAX;
        end else begin
          thr = (thresh == 0) ? THRESH_DEFAULT : thresh;
          hsv_to_point(it.hue, it.saturation, it.brightness, x, y, z);
          best = 0;
          best_id = '0;
          for (int i = 0; i < count; i++) begin
            dx = x - px[i]; dy = y - py[i]; dz = z - pz[i];
            d = floor_root(longint'(dx * dx + dy * dy + dz * dz));
            if (d > 1048575) d = 1048575;
            if (i == 0 || d < best) begin
              best = d; best_id = pid[i];
            end
          end
          r.match_distance = best[19:0];
          r.matched_color = (best > thr) ? 8'd0 : best_id;
        end
      end
      default: ;
    endcase
    r.entries_used = count[5:0];
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      base_val <= BASE_VALUE_RESET;
      thresh <= THRESH_DEFAULT;
      count = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_BASE_VALUE) base_val <= cfg_data[6:0];
        else thresh <= cfg_data;
      end
      if (in_valid && in_ready) predict_item(in_item);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_result.status !== e.status)
            report("status", out_result.status, e.status);
          if (out_result.matched_color !== e.matched_color)
            report("matched_color", out_result.matched_color, e.matched_color);
          if (out_result.match_distance !== e.match_distance)
            report("match_distance", out_result.match_distance, e.match_distance);
          if (out_result.entries_used !== e.entries_used)
            report("entries_used", out_result.entries_used, e.entries_used);
        end
      end
    end
  end

endmodule

### dv/tb_color_prototype_classifier.sv
`timescale 1ns / 1ps
// Top of the classifier testbench. It makes reset, stimulus, receiver stalls and
// register writes; the checker beside the block predicts and compares every transfer.
module tb_color_prototype_classifier;
  import cpc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  result_t     out_result;
  logic        cfg_write_en;
  logic        cfg_index;
  logic [19:0] cfg_data;
  int          fail_count;
  int          pending;

  color_prototype_classifier dut (.*);

  cpc_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Most gaps are short, a few are long, and about a third are none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // The receiver stalls at random, independent of the sender.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Offer one item, hold it until its transfer, then idle for a random gap.
  task automatic send(input logic [1:0] k, input int h, input int s, input int v,
                      input int c);
    int g;
    in_item_t it;
    it.kind = k;
    it.hue = h[8:0];
    it.saturation = s[6:0];
    it.brightness = v[6:0];
    it.proto_color = c[7:0];
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [1:0] k);
    send(k, $urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 127),
         $urandom_range(0, 255));
  endtask

  // Registers change only once the block has drained, plus a margin for the pipeline.
  task automatic write_reg(input logic idx, input logic [19:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    int wait_cycles;
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write_en = 1'b0;
    cfg_index = CFG_BASE_VALUE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-table classify, no-op, extremes of every field, hue wrap,
    // equal distances, a full table with rejected adds, then a clear.
    send(KIND_CLASSIFY, 10, 50, 50, 0);
    send(KIND_NOP, 511, 127, 127, 255);
    send(KIND_ADD, 0, 0, 0, 0);
    send(KIND_ADD, 0, 0, 0, 9);
    send(KIND_CLASSIFY, 0, 0, 0, 0);
    send(KIND_ADD, 359, 100, 100, 255);
    send(KIND_ADD, 511, 127, 127, 170);
    send(KIND_CLASSIFY, 370, 127, 127, 85);
    send(KIND_CLASSIFY, 90, 100, 0, 0);
    for (int i = 0; i < 29; i++) send_random(KIND_ADD);
    send(KIND_ADD, 180, 64, 64, 1);
    send(KIND_CLASSIFY, 270, 1, 1, 0);
    send(KIND_CLEAR, 0, 0, 0, 0);
    send(KIND_CLASSIFY, 45, 50, 50, 0);

    // Random phases across register settings, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_BASE_VALUE, 20'd0); write_reg(CFG_THRESHOLD, 20'd1); end
        1: begin write_reg(CFG_BASE_VALUE, 20'd127); write_reg(CFG_THRESHOLD, 20'hFFFFF); end
        2: begin write_reg(CFG_BASE_VALUE, 20'd5); write_reg(CFG_THRESHOLD, 20'd0); end
        3: begin write_reg(CFG_BASE_VALUE, 20'd6); write_reg(CFG_THRESHOLD, 20'd3000); end
        default: begin
          write_reg(CFG_BASE_VALUE, 20'($urandom_range(0, 127)));
          write_reg(CFG_THRESHOLD, 20'($urandom()));
        end
      endcase
      for (int n = 0; n < 125; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_random(KIND_CLEAR);
        else if (r < 35) send_random(KIND_ADD);
        else if (r < 95) send_random(KIND_CLASSIFY);
        else send_random(KIND_NOP);
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/cpc_pkg.sv
sv/cpc_front.sv
sv/cpc_queue.sv
sv/cpc_isqrt.sv
sv/cpc_back.sv
sv/color_prototype_classifier.sv
dv/cpc_checker.sv
dv/tb_color_prototype_classifier.sv
